@@ sv/text_hex_line_framer_defines.svh @@
// Assertion macros for the text/hex line framer.
`ifndef TEXT_HEX_LINE_FRAMER_DEFINES_SVH
`define TEXT_HEX_LINE_FRAMER_DEFINES_SVH

// Checked at every rising clock edge, reset included.
`define THLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked outside reset only.
`define THLF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

@@ sv/thlf_pkg.sv @@
// Shared constants, types and helpers of the text/hex line framer.
package thlf_pkg;

    localparam int TEXT_LINE_MAX = 77;
    localparam int HEX_LINE_MAX  = 32;
    localparam int OUT_CAP       = 256;

    localparam logic [6:0] MTR_RESET = 7'd20;

    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_GT     = 8'h3e;

    typedef enum logic [2:0] {
        E_DOLLAR = 3'd0,
        E_COLON  = 3'd1,
        E_GT     = 3'd2,
        E_NL     = 3'd3,
        E_HHI    = 3'd4,
        E_HLO    = 3'd5,
        E_TXT    = 3'd6
    } t_esel;

    typedef enum logic [1:0] {
        P_TXT  = 2'd0,
        P_NL   = 2'd1,
        P_BYTE = 2'd2
    } t_psrc;

    typedef struct packed {
        logic  accept;
        logic  tc_inc_wr;
        logic  tc_clr;
        logic  keep_load;
        logic  keep_dec;
        logic  it_clr;
        logic  it_load_keep;
        logic  it_inc;
        logic  ih_clr;
        logic  ih_inc;
        logic  trd_keep;
        logic  trd_it;
        logic  hrd;
        logic  hpush;
        t_psrc psrc;
        logic  hc_clr;
        logic  emit;
        t_esel esel;
        logic  fin;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic is_nl;
        logic is_print;
        logic hc_zero;
        logic hc_full;
        logic tc_zero;
        logic tc_full;
        logic tc_ge_run;
        logic keep_zero;
        logic keep_eq_tc;
        logic it_lt_keep;
        logic it_lt_tc;
        logic ih_lt_hc;
        logic tblank;
        logic emit_ok;
        logic fin_ok;
    } t_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

endpackage

@@ sv/thlf_dp.sv @@
// Datapath: line stores, counters, character packer and output register.
`include "text_hex_line_framer_defines.svh"

module thlf_dp #(
    parameter int TMAX = thlf_pkg::TEXT_LINE_MAX,
    parameter int HMAX = thlf_pkg::HEX_LINE_MAX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  thlf_pkg::t_cmd      i_cmd,
    output thlf_pkg::t_stat     o_st,
    input  logic                i_func,
    input  logic [7:0]          i_data_byte,
    input  logic                i_cfg_valid,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [7:0][7:0]     o_chars,
    output logic [3:0]          o_char_count,
    output logic                o_last
);
    localparam int TW  = $clog2(TMAX + 1);
    localparam int TAW = $clog2(TMAX);
    localparam int HW  = $clog2(HMAX + 1);
    localparam int HAW = (HMAX > 1) ? $clog2(HMAX) : 1;
    localparam int OW  = $clog2(thlf_pkg::OUT_CAP) + 1;

    logic            r_func;
    logic [7:0]      r_byte;
    logic [6:0]      r_mtr;
    logic [TW-1:0]   r_tc, r_keep, r_it;
    logic [HW-1:0]   r_hc, r_ih;
    logic [7:0]      r_tmem [TMAX];
    logic [7:0]      r_hmem [HMAX];
    logic [7:0]      r_trd, r_hrd;
    logic [7:0][7:0] r_pk;
    logic [3:0]      r_pkc;
    logic [OW-1:0]   r_olen;
    logic            r_ovld;
    logic [7:0][7:0] r_oc;
    logic [3:0]      r_ocnt;
    logic            r_olast;

    logic [TAW-1:0]  taddr;
    logic [7:0]      pval, echar;
    logic            drop, move;

    assign taddr = i_cmd.trd_keep ? TAW'(r_keep - TW'(1)) : TAW'(r_it);
    assign drop  = r_olen[OW-1];
    assign move  = (i_cmd.emit && !drop && r_pkc == 4'd8) || (i_cmd.fin && r_pkc != 4'd0);

    always_comb begin
        case (i_cmd.psrc)
            thlf_pkg::P_TXT:  pval = r_trd;
            thlf_pkg::P_NL:   pval = thlf_pkg::CH_NL;
            thlf_pkg::P_BYTE: pval = r_byte;
            default:          pval = r_byte;
        endcase
        case (i_cmd.esel)
            thlf_pkg::E_DOLLAR: echar = thlf_pkg::CH_DOLLAR;
            thlf_pkg::E_COLON:  echar = thlf_pkg::CH_COLON;
            thlf_pkg::E_GT:     echar = thlf_pkg::CH_GT;
            thlf_pkg::E_NL:     echar = thlf_pkg::CH_NL;
            thlf_pkg::E_HHI:    echar = thlf_pkg::hex_char(r_hrd[7:4]);
            thlf_pkg::E_HLO:    echar = thlf_pkg::hex_char(r_hrd[3:0]);
            thlf_pkg::E_TXT:    echar = r_trd;
            default:            echar = thlf_pkg::CH_NL;
        endcase
    end

    always_comb begin
        o_st.func       = r_func;
        o_st.is_nl      = (r_byte == thlf_pkg::CH_NL);
        o_st.is_print   = (r_byte inside {[8'h20:8'h7e]}) || (r_byte == thlf_pkg::CH_TAB);
        o_st.hc_zero    = (r_hc == '0);
        o_st.hc_full    = (r_hc >= HW'(HMAX));
        o_st.tc_zero    = (r_tc == '0);
        o_st.tc_full    = (r_tc >= TW'(TMAX));
        o_st.tc_ge_run  = (7'(r_tc) >= r_mtr);
        o_st.keep_zero  = (r_keep == '0);
        o_st.keep_eq_tc = (r_keep == r_tc);
        o_st.it_lt_keep = (r_it < r_keep);
        o_st.it_lt_tc   = (r_it < r_tc);
        o_st.ih_lt_hc   = (r_ih < r_hc);
        o_st.tblank     = (r_trd == thlf_pkg::CH_SP) || (r_trd == thlf_pkg::CH_TAB);
        o_st.emit_ok    = (r_pkc != 4'd8) || !r_ovld || drop;
        o_st.fin_ok     = (r_pkc == 4'd0) || !r_ovld;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_byte <= i_data_byte;
        end
        if (i_cmd.tc_inc_wr) r_tmem[TAW'(r_tc)] <= r_byte;
        if (i_cmd.trd_keep || i_cmd.trd_it) r_trd <= r_tmem[taddr];
        if (i_cmd.hpush) r_hmem[HAW'(r_hc)] <= pval;
        if (i_cmd.hrd) r_hrd <= r_hmem[HAW'(r_ih)];
        if (i_cmd.emit && !drop) begin
            // first character of a chunk clears the unused tail
            if (r_pkc == 4'd8 || r_pkc == 4'd0) begin
                r_pk <= {56'd0, echar};
            end else begin
                r_pk[r_pkc[2:0]] <= echar;
            end
        end
        if (move) begin
            r_oc    <= r_pk;
            r_ocnt  <= r_pkc;
            r_olast <= i_cmd.fin;
        end
        if (i_cmd.keep_load) r_keep <= r_tc;
        else if (i_cmd.keep_dec) r_keep <= r_keep - TW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtr  <= thlf_pkg::MTR_RESET;
            r_tc   <= '0;
            r_hc   <= '0;
            r_it   <= '0;
            r_ih   <= '0;
            r_pkc  <= '0;
            r_olen <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_valid) r_mtr <= i_cfg_data;
            if (i_cmd.tc_clr) r_tc <= '0;
            else if (i_cmd.tc_inc_wr) r_tc <= r_tc + TW'(1);
            if (i_cmd.hc_clr) r_hc <= '0;
            else if (i_cmd.hpush) r_hc <= r_hc + HW'(1);
            if (i_cmd.it_clr) r_it <= '0;
            else if (i_cmd.it_load_keep) r_it <= r_keep;
            else if (i_cmd.it_inc) r_it <= r_it + TW'(1);
            if (i_cmd.ih_clr) r_ih <= '0;
            else if (i_cmd.ih_inc) r_ih <= r_ih + HW'(1);
            if (i_cmd.fin) begin
                r_pkc  <= '0;
                r_olen <= '0;
            end else if (i_cmd.emit && !drop) begin
                r_olen <= r_olen + OW'(1);
                r_pkc  <= (r_pkc == 4'd8) ? 4'd1 : r_pkc + 4'd1;
            end
            if (move) r_ovld <= 1'b1;
            else if (r_ovld && !i_stall) r_ovld <= 1'b0;
        end
    end

    assign o_valid      = r_ovld;
    assign o_chars      = r_oc;
    assign o_char_count = r_ocnt;
    assign o_last       = r_olast;

    `THLF_ASSERT_RST(a_pk_bound, r_pkc <= 4'd8, "packer count above eight")
    `THLF_ASSERT_RST(a_out_cnt, r_ovld |-> (r_ocnt != 4'd0), "empty item offered")
    `THLF_ASSERT_RST(a_hc_bound, r_hc <= HW'(HMAX), "hex count above line limit")
    `THLF_ASSERT_RST(a_no_lost, (r_ovld && i_stall && !move) |=> $stable(r_oc), "stalled item changed")

endmodule

@@ sv/thlf_ctrl.sv @@
// Controller: sequences buffering, line closing and hex pushes.
module thlf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  thlf_pkg::t_stat i_st,
    output thlf_pkg::t_cmd  o_cmd
);
    typedef enum logic [28:0] {
        S_IDLE = 29'h0000_0001,
        S_DEC  = 29'h0000_0002,
        S_F2   = 29'h0000_0004,
        S_P1   = 29'h0000_0008,
        S_P2   = 29'h0000_0010,
        S_P3   = 29'h0000_0020,
        S_N1   = 29'h0000_0040,
        S_N2   = 29'h0000_0080,
        S_N3   = 29'h0000_0100,
        S_N4   = 29'h0000_0200,
        S_N5   = 29'h0000_0400,
        S_PSH  = 29'h0000_0800,
        S_FIN  = 29'h0000_1000,
        S_H0   = 29'h0000_2000,
        S_H1   = 29'h0000_4000,
        S_H2   = 29'h0000_8000,
        S_H3   = 29'h0001_0000,
        S_H4   = 29'h0002_0000,
        S_T0   = 29'h0004_0000,
        S_T1   = 29'h0008_0000,
        S_T2   = 29'h0010_0000,
        S_T3   = 29'h0020_0000,
        S_T4   = 29'h0040_0000,
        S_T5   = 29'h0080_0000,
        S_T6   = 29'h0100_0000,
        S_T7   = 29'h0200_0000,
        S_T8   = 29'h0400_0000,
        S_T9   = 29'h0800_0000,
        S_T10  = 29'h1000_0000
    } t_state;

    t_state          r_state, n_state;
    t_state          r_hret, n_hret, r_tret, n_tret, r_pret, n_pret;
    logic            r_nl, n_nl;
    thlf_pkg::t_psrc r_psrc, n_psrc;

    always_comb begin
        n_state = r_state;
        n_hret  = r_hret;
        n_tret  = r_tret;
        n_pret  = r_pret;
        n_nl    = r_nl;
        n_psrc  = r_psrc;
        o_cmd   = '0;
        o_cmd.psrc = r_psrc;
        o_cmd.esel = thlf_pkg::E_NL;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_st.func) begin
                    if (!i_st.hc_zero) begin
                        n_hret = S_F2; n_state = S_H0;
                    end else n_state = S_F2;
                end else if (i_st.is_nl && i_st.hc_zero) begin
                    n_nl = 1'b1; n_tret = S_FIN; n_state = S_T0;
                end else if (i_st.is_print) n_state = S_P1;
                else n_state = S_N1;
            end
            S_F2: begin
                if (!i_st.tc_zero) begin
                    n_nl = 1'b0; n_tret = S_FIN; n_state = S_T0;
                end else n_state = S_FIN;
            end
            S_P1: begin
                o_cmd.tc_inc_wr = !i_st.tc_full;
                n_state = S_P2;
            end
            S_P2: begin
                if (!i_st.hc_zero && i_st.tc_ge_run) begin
                    n_hret = S_P3; n_state = S_H0;
                end else n_state = S_P3;
            end
            S_P3: begin
                if (i_st.tc_full) begin
                    n_nl = 1'b0; n_tret = S_FIN; n_state = S_T0;
                end else n_state = S_FIN;
            end
            S_N1: begin
                if (!i_st.tc_zero && i_st.hc_zero) begin
                    n_nl = 1'b0; n_tret = S_N2; n_state = S_T0;
                end else n_state = S_N2;
            end
            S_N2: begin
                o_cmd.it_clr = 1'b1;
                n_state = S_N3;
            end
            S_N3: begin
                if (i_st.it_lt_tc) begin
                    o_cmd.trd_it = 1'b1; n_state = S_N4;
                end else n_state = S_N5;
            end
            S_N4: begin
                o_cmd.it_inc = 1'b1;
                n_psrc = thlf_pkg::P_TXT; n_pret = S_N3; n_state = S_PSH;
            end
            S_N5: begin
                o_cmd.tc_clr = 1'b1;
                n_psrc = thlf_pkg::P_BYTE; n_pret = S_FIN; n_state = S_PSH;
            end
            S_PSH: begin
                if (i_st.hc_full) begin
                    n_hret = S_PSH; n_state = S_H0;
                end else begin
                    o_cmd.hpush = 1'b1; n_state = r_pret;
                end
            end
            S_FIN: begin
                if (i_st.fin_ok) begin
                    o_cmd.fin = 1'b1; n_state = S_IDLE;
                end
            end
            S_H0: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = thlf_pkg::E_DOLLAR;
                    o_cmd.ih_clr = 1'b1; n_state = S_H1;
                end
            end
            S_H1: begin
                if (i_st.ih_lt_hc) begin
                    o_cmd.hrd = 1'b1; n_state = S_H2;
                end else n_state = S_H4;
            end
            S_H2: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = thlf_pkg::E_HHI; n_state = S_H3;
                end
            end
            S_H3: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = thlf_pkg::E_HLO;
                    o_cmd.ih_inc = 1'b1; n_state = S_H1;
                end
            end
            S_H4: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = thlf_pkg::E_NL;
                    o_cmd.hc_clr = 1'b1; n_state = r_hret;
                end
            end
            S_T0: begin
                o_cmd.keep_load = 1'b1; n_state = S_T1;
            end
            S_T1: begin
                if (!i_st.keep_zero) begin
                    o_cmd.trd_keep = 1'b1; n_state = S_T2;
                end else n_state = S_T3;
            end
            S_T2: begin
                if (i_st.tblank) begin
                    o_cmd.keep_dec = 1'b1; n_state = S_T1;
                end else n_state = S_T3;
            end
            S_T3: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = (i_st.keep_eq_tc && r_nl) ? thlf_pkg::E_COLON
                                                           : thlf_pkg::E_GT;
                    o_cmd.it_clr = 1'b1; n_state = S_T4;
                end
            end
            S_T4: begin
                if (i_st.it_lt_keep) begin
                    o_cmd.trd_it = 1'b1; n_state = S_T5;
                end else n_state = S_T6;
            end
            S_T5: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = thlf_pkg::E_TXT;
                    o_cmd.it_inc = 1'b1; n_state = S_T4;
                end
            end
            S_T6: begin
                if (i_st.emit_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = thlf_pkg::E_NL;
                    if (i_st.keep_eq_tc) begin
                        o_cmd.tc_clr = 1'b1; n_state = r_tret;
                    end else begin
                        o_cmd.it_load_keep = 1'b1; n_state = S_T7;
                    end
                end
            end
            S_T7: begin
                if (i_st.it_lt_tc) begin
                    o_cmd.trd_it = 1'b1; n_state = S_T8;
                end else n_state = S_T9;
            end
            S_T8: begin
                o_cmd.it_inc = 1'b1;
                n_psrc = thlf_pkg::P_TXT; n_pret = S_T7; n_state = S_PSH;
            end
            S_T9: begin
                o_cmd.tc_clr = 1'b1;
                if (r_nl) begin
                    n_psrc = thlf_pkg::P_NL; n_pret = S_T10; n_state = S_PSH;
                end else n_state = S_T10;
            end
            S_T10: begin
                n_hret = r_tret; n_state = S_H0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hret  <= S_IDLE;
            r_tret  <= S_IDLE;
            r_pret  <= S_IDLE;
            r_nl    <= 1'b0;
            r_psrc  <= thlf_pkg::P_BYTE;
        end else begin
            r_state <= n_state;
            r_hret  <= n_hret;
            r_tret  <= n_tret;
            r_pret  <= n_pret;
            r_nl    <= n_nl;
            r_psrc  <= n_psrc;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ sv/text_hex_line_framer.sv @@
// Top level of the text/hex line framer: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  input   | in        | i_valid / o_stall     | i_func, i_data_byte
//  output  | out       | o_valid / i_stall     | o_char0..7, o_char_count, o_last
//  config  | in        | i_cfg_valid / ready   | i_cfg_data (min_text_run)
//
// An item that only buffers runs from accept through S_DEC, then S_P1 to S_P3
// (printable byte) or S_N1 to S_N5 and S_PSH (other byte), then S_FIN.
// A closed line is emitted character by character after its trailing-blank
// scan; each character passes through the shared 8-character packer.
// Output stalls hold the packer once a full item waits; the sequencer then waits.
// Synchronous active-low reset clears counts but not r_keep or the stores.
module text_hex_line_framer #(
    parameter int TEXT_LINE_MAX = thlf_pkg::TEXT_LINE_MAX,
    parameter int HEX_LINE_MAX  = thlf_pkg::HEX_LINE_MAX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char0,
    output logic [7:0] o_char1,
    output logic [7:0] o_char2,
    output logic [7:0] o_char3,
    output logic [7:0] o_char4,
    output logic [7:0] o_char5,
    output logic [7:0] o_char6,
    output logic [7:0] o_char7,
    output logic [3:0] o_char_count,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);
    thlf_pkg::t_cmd  cmd;
    thlf_pkg::t_stat st;
    logic [7:0][7:0] chars;

    thlf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    thlf_dp #(
        .TMAX (TEXT_LINE_MAX),
        .HMAX (HEX_LINE_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_chars      (chars),
        .o_char_count (o_char_count),
        .o_last       (o_last)
    );

    assign o_cfg_ready = 1'b1;
    assign o_char0 = chars[0];
    assign o_char1 = chars[1];
    assign o_char2 = chars[2];
    assign o_char3 = chars[3];
    assign o_char4 = chars[4];
    assign o_char5 = chars[5];
    assign o_char6 = chars[6];
    assign o_char7 = chars[7];

endmodule
